[hdl/bdts_pkg.sv]
package bdts_pkg;

  localparam int unsigned EventTimeW = 20;
  localparam int unsigned SlotW      = 12;
  localparam int unsigned SampleW    = 16;
  localparam int unsigned TpsW       = 16;
  localparam int unsigned TpfW       = 20;
  localparam int unsigned CfgIndexW  = 2;
  localparam int unsigned CfgDataW   = 20;
  localparam int unsigned ScaleW     = 15;
  localparam int unsigned QuotW      = 16;
  localparam int unsigned DivCntW    = 4;

  localparam logic [ScaleW-1:0]   ScaleTwice = 15'd20000;
  localparam logic [QuotW-1:0]    QuotMax    = 16'd42767;
  localparam logic [QuotW:0]      VolumeOff  = 17'd10000;
  localparam logic [SampleW-1:0]  SampleMax  = 16'h7FFF;
  localparam logic [DivCntW-1:0]  DivLast    = 4'd15;

  localparam logic [TpsW-1:0]  TpsReset  = 16'd72;
  localparam logic [SlotW-1:0] SpfReset  = 12'd960;
  localparam logic [TpfW-1:0]  TpfReset  = 20'd69888;

  typedef enum logic [CfgIndexW-1:0] {
    REG_TICKS_PER_SAMPLE  = 2'd0,
    REG_SAMPLES_PER_FRAME = 2'd1,
    REG_TICKS_PER_FRAME   = 2'd2,
    REG_MUTE              = 2'd3
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DELTA,
    ST_SUM,
    ST_INTEG,
    ST_MUL,
    ST_DCHK,
    ST_DIV,
    ST_SCALE,
    ST_MIX,
    ST_FRAME,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [EventTimeW-1:0] event_time;
    logic                  speaker_level;
    logic                  tape_level;
  } in_item_t;

  typedef struct packed {
    logic                      sample_valid;
    logic signed [SampleW-1:0] sample_value;
    logic [SlotW-1:0]          slot_index;
    logic                      fill_half_out;
    logic                      frame_swap;
  } out_item_t;

endpackage

[hdl/beeper_duty_to_sample_unit.sv]
// Channel  | Signals                                   | Direction
// ---------+-------------------------------------------+----------
// in       | in_valid_i, in_ready_o, in_data_i         | input
// out      | out_valid_o, out_ready_i, out_data_o      | output
// cfg      | cfg_valid_i, cfg_ready_o, cfg_index_i,    | input
//          | cfg_data_i                                |
//
// An item that completes no sample passes idle, delta, sum, integrate, frame and done; when the
// frame is full it skips integrate. One that completes a sample also passes the shared multiply and 16-step
// restoring divider that scale the speaker and then the tape high-time; a quotient that
// overflows 16 bits skips its divide steps. The result waits in an output register,
// loaded as the block returns to idle to take input again, and loading stalls while it is still full.
// Reset is asynchronous and loads the register defaults; cfg is always ready.
module beeper_duty_to_sample_unit #(
  parameter int unsigned TimeBits = 21
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  bdts_pkg::in_item_t                   in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output bdts_pkg::out_item_t                  out_data_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [bdts_pkg::CfgIndexW-1:0]       cfg_index_i,
  input  logic [bdts_pkg::CfgDataW-1:0]        cfg_data_i
);

  localparam int unsigned AccW =
    (TimeBits > bdts_pkg::EventTimeW ? TimeBits : bdts_pkg::EventTimeW) + 1;
  localparam int unsigned ProdW = TimeBits + bdts_pkg::ScaleW;
  localparam int unsigned CmpW  = ProdW > 32 ? ProdW : 32;
  localparam logic [TimeBits-1:0] TimeMax = {TimeBits{1'b1}};

  localparam int unsigned EtW = bdts_pkg::EventTimeW;
  localparam int unsigned SlW = bdts_pkg::SlotW;
  localparam int unsigned SmW = bdts_pkg::SampleW;
  localparam int unsigned QW  = bdts_pkg::QuotW;

  function automatic logic [TimeBits-1:0] sat_time(input logic [AccW-1:0] v);
    logic [TimeBits-1:0] r;
    r = (v > AccW'(TimeMax)) ? TimeMax : v[TimeBits-1:0];
    return r;
  endfunction

  bdts_pkg::state_e state_q, state_d;

  logic [bdts_pkg::TpsW-1:0] tps_cfg_q;
  logic [SlW-1:0]            spf_q;
  logic [bdts_pkg::TpfW-1:0] tpf_q;
  logic                      mute_q;

  logic [EtW-1:0]            t_q, t_d;
  logic                      spk_q, spk_d, tap_q, tap_d;
  logic [bdts_pkg::TpsW-1:0] tps_q, tps_d;
  logic                      active_q, active_d, swap_q, swap_d;

  logic [EtW-1:0]      last_q, last_d, dt_q, dt_d;
  logic [TimeBits-1:0] period_q, period_d, hs_q, hs_d, ht_q, ht_d;
  logic [SlW-1:0]      slot_q, slot_d;
  logic                half_q, half_d;

  logic [AccW-1:0]           sum_q, sum_d;
  logic [bdts_pkg::TpsW-1:0] rest_q, rest_d;
  logic [TimeBits-1:0]       cls_s_q, cls_s_d, cls_t_q, cls_t_d;
  logic                      sel_q, sel_d;
  logic [ProdW-1:0]          prod_q, prod_d;
  logic [QW-1:0]             rem_q, rem_d, lo_q, lo_d;
  logic                      ovf_q, ovf_d;
  logic [bdts_pkg::DivCntW-1:0] cnt_q, cnt_d;
  logic signed [SmW-1:0]     s_q, s_d, k_q, k_d, val_q, val_d;
  logic                      ovalid_q, ovalid_d, ohalf_q, ohalf_d;
  logic [SlW-1:0]            oslot_q, oslot_d;

  bdts_pkg::out_item_t out_q, out_d;
  logic                out_valid_q, out_valid_d;

  logic                 in_fire, out_free, close;
  logic [AccW-1:0]      rem_dt;
  logic [CmpW-1:0]      prod_ext, tps_shift;
  logic [QW:0]          trial;
  logic                 trial_ge;
  logic signed [QW:0]   diff;
  logic signed [SmW:0]  msum, mround;
  logic [TimeBits-1:0]  op;

  assign in_ready_o  = (state_q == bdts_pkg::ST_IDLE);
  assign in_fire     = in_valid_i & in_ready_o;
  assign out_free    = ~out_valid_q | out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

  assign close     = sum_q > AccW'(tps_q);
  assign rem_dt    = sum_q - AccW'(tps_q);
  assign op        = sel_q ? cls_t_q : cls_s_q;
  assign prod_ext  = CmpW'(prod_q);
  assign tps_shift = CmpW'({tps_q, 16'd0});
  assign trial     = {rem_q, lo_q[QW-1]};
  assign trial_ge  = trial >= {1'b0, tps_q};
  assign diff      = $signed({1'b0, lo_q}) - $signed(bdts_pkg::VolumeOff);
  assign msum      = {s_q[SmW-1], s_q} + {k_q[SmW-1], k_q};
  assign mround    = msum + (SmW+1)'(msum[SmW] & msum[0]);

  always_comb begin
    state_d = state_q;
    case (state_q)
      bdts_pkg::ST_IDLE:  if (in_fire) state_d = bdts_pkg::ST_DELTA;
      bdts_pkg::ST_DELTA: state_d = bdts_pkg::ST_SUM;
      bdts_pkg::ST_SUM:   state_d = active_q ? bdts_pkg::ST_INTEG : bdts_pkg::ST_FRAME;
      bdts_pkg::ST_INTEG: state_d = close ? bdts_pkg::ST_MUL : bdts_pkg::ST_FRAME;
      bdts_pkg::ST_MUL:   state_d = bdts_pkg::ST_DCHK;
      bdts_pkg::ST_DCHK:  state_d = (prod_ext >= tps_shift) ? bdts_pkg::ST_SCALE
                                                             : bdts_pkg::ST_DIV;
      bdts_pkg::ST_DIV:   if (cnt_q == bdts_pkg::DivLast) state_d = bdts_pkg::ST_SCALE;
      bdts_pkg::ST_SCALE: state_d = sel_q ? bdts_pkg::ST_MIX : bdts_pkg::ST_MUL;
      bdts_pkg::ST_MIX:   state_d = bdts_pkg::ST_FRAME;
      bdts_pkg::ST_FRAME: state_d = bdts_pkg::ST_DONE;
      bdts_pkg::ST_DONE:  if (out_free) state_d = bdts_pkg::ST_IDLE;
      default:            state_d = bdts_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    t_d = t_q; spk_d = spk_q; tap_d = tap_q; tps_d = tps_q;
    active_d = active_q; swap_d = swap_q;
    last_d = last_q; dt_d = dt_q; period_d = period_q;
    hs_d = hs_q; ht_d = ht_q; slot_d = slot_q; half_d = half_q;
    sum_d = sum_q; rest_d = rest_q; cls_s_d = cls_s_q; cls_t_d = cls_t_q;
    sel_d = sel_q; prod_d = prod_q; rem_d = rem_q; lo_d = lo_q; ovf_d = ovf_q;
    cnt_d = cnt_q; s_d = s_q; k_d = k_q; val_d = val_q;
    ovalid_d = ovalid_q; ohalf_d = ohalf_q; oslot_d = oslot_q;
    out_d = out_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    case (state_q)
      bdts_pkg::ST_IDLE: begin
        if (in_fire) begin
          t_d      = in_data_i.event_time;
          spk_d    = in_data_i.speaker_level & ~mute_q;
          tap_d    = in_data_i.tape_level;
          tps_d    = (tps_cfg_q == '0) ? bdts_pkg::TpsW'(1) : tps_cfg_q;
          active_d = slot_q < spf_q;
          swap_d   = EtW'(in_data_i.event_time) >= tpf_q;
          ovalid_d = 1'b0;
          val_d    = '0;
          oslot_d  = '0;
          ohalf_d  = 1'b0;
          sel_d    = 1'b0;
        end
      end
      bdts_pkg::ST_DELTA: begin
        dt_d   = (t_q >= last_q) ? t_q - last_q : '0;
        last_d = swap_q ? t_q - tpf_q : t_q;
      end
      bdts_pkg::ST_SUM: begin
        sum_d  = AccW'(period_q) + AccW'(dt_q);
        rest_d = (AccW'(period_q) < AccW'(tps_q)) ? tps_q - bdts_pkg::TpsW'(period_q)
                                                   : '0;
      end
      bdts_pkg::ST_INTEG: begin
        if (close) begin
          cls_s_d  = spk_q ? sat_time(AccW'(hs_q) + AccW'(rest_q)) : hs_q;
          cls_t_d  = tap_q ? sat_time(AccW'(ht_q) + AccW'(rest_q)) : ht_q;
          hs_d     = spk_q ? sat_time(rem_dt) : '0;
          ht_d     = tap_q ? sat_time(rem_dt) : '0;
          period_d = sat_time(rem_dt);
          ovalid_d = 1'b1;
          oslot_d  = slot_q;
          ohalf_d  = half_q;
          slot_d   = slot_q + SlW'(1);
        end else begin
          if (spk_q) hs_d = sat_time(AccW'(hs_q) + AccW'(dt_q));
          if (tap_q) ht_d = sat_time(AccW'(ht_q) + AccW'(dt_q));
          period_d = sat_time(sum_q);
        end
      end
      bdts_pkg::ST_MUL: begin
        prod_d = ProdW'(op) * ProdW'(bdts_pkg::ScaleTwice);
      end
      bdts_pkg::ST_DCHK: begin
        ovf_d = prod_ext >= tps_shift;
        rem_d = prod_ext[31:16];
        lo_d  = prod_ext[15:0];
        cnt_d = '0;
      end
      bdts_pkg::ST_DIV: begin
        rem_d = trial_ge ? QW'(trial - {1'b0, tps_q}) : trial[QW-1:0];
        lo_d  = {lo_q[QW-2:0], trial_ge};
        cnt_d = cnt_q + bdts_pkg::DivCntW'(1);
      end
      bdts_pkg::ST_SCALE: begin
        if (sel_q) begin
          k_d = (ovf_q || lo_q > bdts_pkg::QuotMax) ? bdts_pkg::SampleMax : diff[SmW-1:0];
        end else begin
          s_d = (ovf_q || lo_q > bdts_pkg::QuotMax) ? bdts_pkg::SampleMax : diff[SmW-1:0];
        end
        sel_d = 1'b1;
      end
      bdts_pkg::ST_MIX: begin
        val_d = mround[SmW:1];
      end
      bdts_pkg::ST_FRAME: begin
        if (swap_q) begin
          slot_d = '0;
          half_d = ~half_q;
        end
      end
      bdts_pkg::ST_DONE: begin
        if (out_free) begin
          out_d.sample_valid  = ovalid_q;
          out_d.sample_value  = val_q;
          out_d.slot_index    = oslot_q;
          out_d.fill_half_out = ohalf_q;
          out_d.frame_swap    = swap_q;
          out_valid_d         = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bdts_pkg::ST_IDLE;
      tps_cfg_q   <= bdts_pkg::TpsReset;
      spf_q       <= bdts_pkg::SpfReset;
      tpf_q       <= bdts_pkg::TpfReset;
      mute_q      <= 1'b0;
      last_q      <= '0;
      period_q    <= '0;
      hs_q        <= '0;
      ht_q        <= '0;
      slot_q      <= '0;
      half_q      <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      last_q      <= last_d;
      period_q    <= period_d;
      hs_q        <= hs_d;
      ht_q        <= ht_d;
      slot_q      <= slot_d;
      half_q      <= half_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        case (bdts_pkg::cfg_reg_e'(cfg_index_i))
          bdts_pkg::REG_TICKS_PER_SAMPLE:  tps_cfg_q <= cfg_data_i[bdts_pkg::TpsW-1:0];
          bdts_pkg::REG_SAMPLES_PER_FRAME: spf_q     <= cfg_data_i[SlW-1:0];
          bdts_pkg::REG_TICKS_PER_FRAME:   tpf_q     <= cfg_data_i[bdts_pkg::TpfW-1:0];
          bdts_pkg::REG_MUTE:              mute_q    <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    t_q      <= t_d;
    spk_q    <= spk_d;
    tap_q    <= tap_d;
    tps_q    <= tps_d;
    active_q <= active_d;
    swap_q   <= swap_d;
    dt_q     <= dt_d;
    sum_q    <= sum_d;
    rest_q   <= rest_d;
    cls_s_q  <= cls_s_d;
    cls_t_q  <= cls_t_d;
    sel_q    <= sel_d;
    prod_q   <= prod_d;
    rem_q    <= rem_d;
    lo_q     <= lo_d;
    ovf_q    <= ovf_d;
    cnt_q    <= cnt_d;
    s_q      <= s_d;
    k_q      <= k_d;
    val_q    <= val_d;
    ovalid_q <= ovalid_d;
    ohalf_q  <= ohalf_d;
    oslot_q  <= oslot_d;
    out_q    <= out_d;
  end

endmodule

[verif/beeper_duty_to_sample_unit_tb.sv]
`timescale 1ns / 1ps

module beeper_duty_to_sample_unit_tb;

  localparam int unsigned TimeW = 21;
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned DrainCycles = 60;
  localparam longint Volume = 10000;
  localparam logic [bdts_pkg::EventTimeW-1:0] TimeTop = '1;

  typedef longint unsigned tick_t;
  localparam tick_t TickMax = (64'd1 << TimeW) - 64'd1;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  bdts_pkg::in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  bdts_pkg::out_item_t out_data_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [bdts_pkg::CfgIndexW-1:0] cfg_index_i = '0;
  logic [bdts_pkg::CfgDataW-1:0] cfg_data_i = '0;

  beeper_duty_to_sample_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  logic [bdts_pkg::TpsW-1:0]  r_tps  = bdts_pkg::TpsReset;
  logic [bdts_pkg::SlotW-1:0] r_spf  = bdts_pkg::SpfReset;
  logic [bdts_pkg::TpfW-1:0]  r_tpf  = bdts_pkg::TpfReset;
  logic                       r_mute = 1'b0;

  tick_t                      m_last      = 64'd0;
  tick_t                      m_period    = 64'd0;
  tick_t                      m_spk_high  = 64'd0;
  tick_t                      m_tape_high = 64'd0;
  logic [bdts_pkg::SlotW-1:0] m_slot      = '0;
  logic                       m_half      = 1'b1;

  bdts_pkg::out_item_t pending_samples[$];

  bit          idle_en = 1'b1;
  int unsigned mismatches = 0;
  int unsigned events_sent = 0;
  int unsigned samples_seen = 0;
  int unsigned swaps_seen = 0;
  int unsigned settings_used = 0;
  int unsigned quiet_cycles = 0;
  int unsigned stall_left = 0;

  function automatic tick_t add_sat(tick_t a, longint unsigned b);
    longint unsigned s;
    s = a + b;
    return (s > TickMax) ? TickMax : s;
  endfunction

  function automatic int scale_high(tick_t high, longint unsigned per);
    longint unsigned q;
    longint v;
    q = (high * 64'(2 * Volume)) / per;
    v = $signed(q) - Volume;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return int'(v);
  endfunction

  function automatic bdts_pkg::out_item_t resample_event(bdts_pkg::in_item_t ev);
    bdts_pkg::out_item_t r;
    longint unsigned t, tps, dt, rest;
    logic spk, tap;
    int s, k;
    r = '0;
    t = 64'(ev.event_time);
    spk = ev.speaker_level & ~r_mute;
    tap = ev.tape_level;
    tps = (r_tps == '0) ? 64'd1 : 64'(r_tps);
    if (m_slot < r_spf) begin
      dt = (t >= m_last) ? t - m_last : 64'd0;
      if (m_period + dt > tps) begin
        rest = (m_period < tps) ? tps - m_period : 64'd0;
        if (spk) m_spk_high = add_sat(m_spk_high, rest);
        if (tap) m_tape_high = add_sat(m_tape_high, rest);
        s = scale_high(m_spk_high, tps);
        k = scale_high(m_tape_high, tps);
        r.sample_valid = 1'b1;
        r.sample_value = bdts_pkg::SampleW'((s + k) / 2);
        r.slot_index = m_slot;
        r.fill_half_out = m_half;
        m_slot = m_slot + bdts_pkg::SlotW'(1);
        dt = m_period + dt - tps;
        m_spk_high = 64'd0;
        m_tape_high = 64'd0;
        m_period = 64'd0;
      end
      if (spk) m_spk_high = add_sat(m_spk_high, dt);
      if (tap) m_tape_high = add_sat(m_tape_high, dt);
      m_period = add_sat(m_period, dt);
    end
    m_last = t;
    if (t >= 64'(r_tpf)) begin
      m_slot = '0;
      m_half = ~m_half;
      m_last = t - 64'(r_tpf);
      r.frame_swap = 1'b1;
    end
    return r;
  endfunction

  function automatic void report_mismatch(string what, bdts_pkg::out_item_t want,
                                          bdts_pkg::out_item_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch (%s): expected valid=%0d value=%0d slot=%0d half=%0d swap=%0d",
               what, want.sample_valid, $signed(want.sample_value), want.slot_index,
               want.fill_half_out, want.frame_swap);
      $display("                got valid=%0d value=%0d slot=%0d half=%0d swap=%0d",
               got.sample_valid, $signed(got.sample_value), got.slot_index,
               got.fill_half_out, got.frame_swap);
    end
  endfunction

  always @(posedge clk_i) begin
    bdts_pkg::out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_samples.size() == 0) begin
        report_mismatch("no item pending", '0, out_data_o);
      end else begin
        want = pending_samples.pop_front();
        if (out_data_o.sample_valid !== want.sample_valid ||
            out_data_o.sample_value !== want.sample_value ||
            out_data_o.slot_index !== want.slot_index ||
            out_data_o.fill_half_out !== want.fill_half_out ||
            out_data_o.frame_swap !== want.frame_swap) begin
          report_mismatch("field", want, out_data_o);
        end
        if (want.sample_valid) samples_seen++;
        if (want.frame_swap) swaps_seen++;
      end
    end
  end

  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 9);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("beeper_duty_to_sample_unit_tb: errors");
      $finish;
    end
  end

  task automatic send_event(input logic [bdts_pkg::EventTimeW-1:0] t, input logic spk,
                            input logic tap);
    bdts_pkg::in_item_t ev;
    int unsigned gap;
    ev.event_time = t;
    ev.speaker_level = spk;
    ev.tape_level = tap;
    gap = (idle_en && $urandom_range(0, 2) == 0) ? $urandom_range(1, 10) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= ev;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_samples.push_back(resample_event(ev));
    events_sent++;
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_samples.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [bdts_pkg::TpsW-1:0] tps,
                            input logic [bdts_pkg::SlotW-1:0] spf,
                            input logic [bdts_pkg::TpfW-1:0] tpf, input logic mute);
    bdts_pkg::cfg_reg_e idx;
    logic [bdts_pkg::CfgDataW-1:0] value;
    drain_results();
    idx = bdts_pkg::REG_TICKS_PER_SAMPLE;
    repeat (4) begin
      case (idx)
        bdts_pkg::REG_TICKS_PER_SAMPLE: begin
          value = bdts_pkg::CfgDataW'(tps);
          r_tps = tps;
        end
        bdts_pkg::REG_SAMPLES_PER_FRAME: begin
          value = bdts_pkg::CfgDataW'(spf);
          r_spf = spf;
        end
        bdts_pkg::REG_TICKS_PER_FRAME: begin
          value = bdts_pkg::CfgDataW'(tpf);
          r_tpf = tpf;
        end
        default: begin
          value = bdts_pkg::CfgDataW'(mute);
          r_mute = mute;
        end
      endcase
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx;
      cfg_data_i <= value;
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      idx = idx.next();
    end
    cfg_valid_i <= 1'b0;
    settings_used++;
  endtask

  task automatic random_config(input bit wide);
    logic [bdts_pkg::TpsW-1:0] tps;
    logic [bdts_pkg::SlotW-1:0] spf;
    logic [bdts_pkg::TpfW-1:0] tpf;
    if (wide) begin
      tps = ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                        : bdts_pkg::TpsW'($urandom_range(1000, 65535));
      tpf = ($urandom_range(0, 3) == 0) ? TimeTop
                                        : bdts_pkg::TpfW'($urandom_range(200000, TimeTop));
      spf = ($urandom_range(0, 1) == 0) ? 12'hFFF
                                        : bdts_pkg::SlotW'($urandom_range(1, 20));
    end else begin
      tps = bdts_pkg::TpsW'($urandom_range(1, 40));
      tpf = bdts_pkg::TpfW'(32'(tps) * $urandom_range(3, 24) +
                            $urandom_range(0, 32'(tps)));
      spf = ($urandom_range(0, 2) == 0) ? bdts_pkg::SlotW'($urandom_range(1, 12))
                                        : bdts_pkg::SlotW'($urandom_range(13, 4095));
      if ($urandom_range(0, 9) == 0) tps = '0;
    end
    set_config(tps, spf, tpf, $urandom_range(0, 3) == 0);
  endtask

  // Times mostly advance from where the frame stands, so frames fill and swap.
  task automatic run_frames(input int unsigned n_items);
    longint unsigned t, step_max;
    logic spk, tap;
    spk = 1'($urandom_range(0, 1));
    tap = 1'($urandom_range(0, 1));
    repeat (n_items) begin
      step_max = 64'd2 * ((r_tps == '0) ? 64'd1 : 64'(r_tps)) + 64'd1;
      if ($urandom_range(0, 2) == 0) spk = ~spk;
      if ($urandom_range(0, 2) == 0) tap = ~tap;
      case ($urandom_range(0, 9))
        0: t = 64'($urandom_range(0, TimeTop));
        1: t = m_last;
        2: t = m_last + 64'($urandom_range(0, 32'(r_tpf) + 32'd1));
        default: t = m_last + 64'($urandom_range(1, 32'(step_max)));
      endcase
      if (t > 64'(TimeTop)) t = 64'(TimeTop);
      send_event(bdts_pkg::EventTimeW'(t), spk, tap);
    end
  endtask

  task automatic test_reset_defaults();
    send_event(20'd10, 1'b1, 1'b0);
    send_event(20'd50, 1'b1, 1'b1);
    send_event(20'd100, 1'b0, 1'b1);
    send_event(20'd90, 1'b1, 1'b1);
    send_event(20'd300, 1'b1, 1'b1);
    send_event(20'd400, 1'b0, 1'b0);
    send_event(20'd0, 1'b0, 1'b0);
    send_event(TimeTop, 1'b1, 1'b1);
    send_event(20'd0, 1'b1, 1'b1);
  endtask

  task automatic test_register_extremes();
    set_config(16'd0, 12'hFFF, TimeTop, 1'b0);
    send_event(20'd5, 1'b1, 1'b0);
    send_event(20'd6, 1'b0, 1'b1);
    send_event(20'd20, 1'b1, 1'b1);
    set_config(16'hFFFF, 12'hFFF, TimeTop, 1'b1);
    send_event(20'd40000, 1'b1, 1'b1);
    send_event(20'd45000, 1'b1, 1'b0);
    set_config(16'd1, 12'hFFF, TimeTop, 1'b1);
    send_event(20'd45000, 1'b1, 1'b1);
    send_event(20'd45010, 1'b1, 1'b1);
    set_config(16'd8, 12'd0, 20'd1000, 1'b0);
    send_event(20'd100, 1'b1, 1'b1);
    send_event(20'd2000, 1'b1, 1'b1);
    send_event(20'd50, 1'b1, 1'b0);
    set_config(16'd8, 12'd1, 20'd0, 1'b0);
    send_event(20'd0, 1'b1, 1'b1);
    send_event(20'd30, 1'b1, 1'b1);
    send_event(TimeTop, 1'b1, 1'b1);
    set_config(16'd4, 12'd1, 20'd500, 1'b0);
    send_event(20'd10, 1'b1, 1'b1);
    send_event(20'd20, 1'b1, 1'b1);
    send_event(20'd600, 1'b0, 1'b1);
  endtask

  task automatic test_random_frames();
    repeat (6) begin
      idle_en = ($urandom_range(0, 3) != 0);
      random_config(1'b0);
      run_frames(120);
    end
    idle_en = 1'b1;
  endtask

  task automatic test_wide_periods();
    repeat (2) begin
      random_config(1'b1);
      run_frames(50);
    end
  endtask

  task automatic test_drain_pressure();
    random_config(1'b0);
    repeat (4) begin
      run_frames(25);
      drain_results();
    end
  endtask

  task automatic test_back_to_back();
    idle_en = 1'b0;
    random_config(1'b0);
    run_frames(75);
    random_config(1'b0);
    run_frames(75);
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_defaults();
    test_register_extremes();
    test_random_frames();
    test_wide_periods();
    test_drain_pressure();
    test_back_to_back();
    drain_results();
    repeat (DrainCycles) @(posedge clk_i);
    $display("Sent %0d events under %0d register settings after the reset defaults.",
             events_sent, settings_used);
    $display("Checked %0d completed samples and %0d frame swaps.", samples_seen, swaps_seen);
    if (mismatches == 0 && pending_samples.size() == 0) begin
      $display("beeper_duty_to_sample_unit_tb: clean");
    end else begin
      $display("beeper_duty_to_sample_unit_tb: errors");
    end
    $finish;
  end

endmodule
